// ===== hw/rtl/bres_pkg.sv =====
// Shared types and constants for the line rasterizer.
package bres_pkg;

    localparam int PORT_COORD_W = 6;
    localparam int COLOR_W      = 8;
    localparam int CFG_W        = 7;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_USED_W   = 2 * PORT_COORD_W + 3 * COLOR_W;

    typedef logic [0:0] cfg_idx_t;

    localparam cfg_idx_t REG_IMAGE_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_SIZE_RST = 7'd64;

    // Direction of the walk, fixed for one line.
    typedef struct packed {
        logic xmajor;
        logic x_dec;
        logic y_dec;
    } bres_dir_t;

endpackage

// ===== hw/rtl/bres_step.sv =====
// Error accumulate, compare and coordinate step unit, used once per step from one pixel to the next.
module bres_step #(
    parameter int COORD_BITS = 6
) (
    input  logic [COORD_BITS-1:0] x,
    input  logic [COORD_BITS-1:0] y,
    input  logic [COORD_BITS-1:0] err,
    input  logic [COORD_BITS-1:0] major,
    input  logic [COORD_BITS-1:0] minor,
    input  bres_pkg::bres_dir_t   dir,
    output logic [COORD_BITS-1:0] x_next,
    output logic [COORD_BITS-1:0] y_next,
    output logic [COORD_BITS-1:0] err_next
);
    import bres_pkg::*;

    localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

    logic [COORD_BITS:0]   sum;
    logic                  over;
    logic [COORD_BITS:0]   sum_sub;
    logic [COORD_BITS-1:0] x_step;
    logic [COORD_BITS-1:0] y_step;

    always_comb
    begin
        sum     = {1'b0, err} + {1'b0, minor};
        over    = sum > {1'b0, major};
        sum_sub = sum - {1'b0, major};
        // err never exceeds major, so the low bits hold the whole value
        err_next = over ? sum_sub[COORD_BITS-1:0] : sum[COORD_BITS-1:0];
        x_step   = dir.x_dec ? x - ONE : x + ONE;
        y_step   = dir.y_dec ? y - ONE : y + ONE;
        if (dir.xmajor)
        begin
            x_next = x_step;
            y_next = over ? y_step : y;
        end
        else
        begin
            y_next = y_step;
            x_next = over ? x_step : x;
        end
    end

endmodule

// ===== hw/rtl/bresenham_line_rasterizer.sv =====
// After a line request is accepted, the setup state runs before the first pixel is offered.
// Throughput: one pixel per cycle while m_tready is high; a line of major
// delta D gives D+1 pixels, with one step of the error/step unit between
// successive pixels. No new request is taken until the last pixel leaves.
// Reset (rst_n low, asynchronous): idle, image size registers back to 64 by 64.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  bres_pkg::cfg_idx_t                cfg_index,
    input  logic [bres_pkg::CFG_W-1:0]        cfg_data,
    // line request
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x, start_y, end_x, end_y, red_in, green_in, blue_in
    input  logic [bres_pkg::IN_TDATA_W-1:0]   s_tdata,
    // pixels
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_x, pixel_y, red_out, green_out, blue_out, zero pad
    output logic [bres_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // inside_res
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import bres_pkg::*;

    localparam int C = COORD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   width_reg, width_next;
    logic [CFG_W-1:0]   height_reg, height_next;

    logic [C-1:0]       x_reg, x_next;
    logic [C-1:0]       y_reg, y_next;
    logic [C-1:0]       ex_reg, ex_next;
    logic [C-1:0]       ey_reg, ey_next;
    logic [C-1:0]       err_reg, err_next;
    logic [C-1:0]       major_reg, major_next;
    logic [C-1:0]       minor_reg, minor_next;
    logic [C-1:0]       cnt_reg, cnt_next;
    bres_dir_t          dir_reg, dir_next;
    logic [3*COLOR_W-1:0] color_reg, color_next;

    logic [C-1:0]       dx, dy;
    logic [C-1:0]       st_x, st_y, st_err;
    logic               s_fire, m_fire;

    bres_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .x        (x_reg),
        .y        (y_reg),
        .err      (err_reg),
        .major    (major_reg),
        .minor    (minor_reg),
        .dir      (dir_reg),
        .x_next   (st_x),
        .y_next   (st_y),
        .err_next (st_err)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_EMIT);
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;

    assign m_tdata = {
        (OUT_TDATA_W - OUT_USED_W)'(0),
        color_reg,
        PORT_COORD_W'(y_reg),
        PORT_COORD_W'(x_reg)
    };
    assign m_tuser = (CFG_W'(x_reg) < width_reg) && (CFG_W'(y_reg) < height_reg);
    assign m_tlast = (cnt_reg == '0);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        err_next   = err_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        cnt_next   = cnt_reg;
        dir_next   = dir_reg;
        color_next = color_reg;

        dx = (ex_reg > x_reg) ? ex_reg - x_reg : x_reg - ex_reg;
        dy = (ey_reg > y_reg) ? ey_reg - y_reg : y_reg - ey_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    x_next     = s_tdata[C-1:0];
                    y_next     = s_tdata[PORT_COORD_W +: C];
                    ex_next    = s_tdata[2*PORT_COORD_W +: C];
                    ey_next    = s_tdata[3*PORT_COORD_W +: C];
                    color_next = s_tdata[4*PORT_COORD_W +: 3*COLOR_W];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                // x is the major axis only when dx is strictly larger
                dir_next.xmajor = dx > dy;
                dir_next.x_dec  = !(x_reg < ex_reg);
                dir_next.y_dec  = !(y_reg < ey_reg);
                major_next      = (dx > dy) ? dx : dy;
                minor_next      = (dx > dy) ? dy : dx;
                err_next        = major_next >> 1;
                cnt_next        = major_next;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_fire)
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        x_next   = st_x;
                        y_next   = st_y;
                        err_next = st_err;
                        cnt_next = cnt_reg - C'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            width_reg  <= IMAGE_SIZE_RST;
            height_reg <= IMAGE_SIZE_RST;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        err_reg   <= err_next;
        major_reg <= major_next;
        minor_reg <= minor_next;
        dir_reg   <= dir_next;
        color_reg <= color_next;
    end

endmodule

// ===== hw/rtl/bres_chk.sv =====
// Port-level checker for the line rasterizer, bound to the top level.
module bres_chk (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [bres_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              m_tlast
);
    import bres_pkg::*;

    // a stalled pixel holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel changed while stalled");

    // a new request never overlaps pixels of the previous line
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid)
        else $error("request accepted while pixels pending");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("pixels continue after last");

endmodule

bind bresenham_line_rasterizer bres_chk u_bres_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== verif/tb_bresenham_line_rasterizer.sv =====
// Self-checking testbench for the Bresenham line rasterizer.
module tb_bresenham_line_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import bres_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASES         = 6;
    localparam int LINES_PER_PH   = 60;

    typedef struct packed {
        logic [5:0] x0;
        logic [5:0] y0;
        logic [5:0] x1;
        logic [5:0] y1;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } line_cmd_t;

    typedef struct packed {
        logic [5:0] x;
        logic [5:0] y;
        logic       in_img;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       plast;
    } pixel_t;

    // typed = 1: the row gives its single expected pixel (color is the line color)
    typedef struct packed {
        logic [5:0] x0;
        logic [5:0] y0;
        logic [5:0] x1;
        logic [5:0] y1;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       typed;
        logic [5:0] ex;
        logic [5:0] ey;
        logic       ein;
        logic       elast;
    } dir_row_t;

    // All rows run with the reset image size of 64 by 64.
    localparam dir_row_t DIRECTED [20] = '{
        '{ 0,  0,  0,  0, 8'h00, 8'h00, 8'h00, 1'b1,  0,  0, 1'b1, 1'b1},
        '{63, 63, 63, 63, 8'hff, 8'hff, 8'hff, 1'b1, 63, 63, 1'b1, 1'b1},
        '{21, 42, 21, 42, 8'haa, 8'h55, 8'ha5, 1'b1, 21, 42, 1'b1, 1'b1},
        '{ 0,  0, 63,  0, 8'h12, 8'h34, 8'h56, 1'b0,  0,  0, 1'b0, 1'b0},
        '{63,  0,  0,  0, 8'h55, 8'haa, 8'h0f, 1'b0,  0,  0, 1'b0, 1'b0},
        '{ 0,  0,  0, 63, 8'hf0, 8'h0f, 8'h3c, 1'b0,  0,  0, 1'b0, 1'b0},
        '{ 0, 63,  0,  0, 8'hc3, 8'h81, 8'h7e, 1'b0,  0,  0, 1'b0, 1'b0},
        '{ 0,  0, 63, 63, 8'h01, 8'h02, 8'h04, 1'b0,  0,  0, 1'b0, 1'b0},
        '{63,  0,  0, 63, 8'h08, 8'h10, 8'h20, 1'b0,  0,  0, 1'b0, 1'b0},
        '{ 0,  0, 63, 62, 8'h40, 8'h80, 8'hff, 1'b0,  0,  0, 1'b0, 1'b0},
        '{ 0,  0, 62, 63, 8'hfe, 8'hfd, 8'hfb, 1'b0,  0,  0, 1'b0, 1'b0},
        '{10, 10, 11, 10, 8'hf7, 8'hef, 8'hdf, 1'b0,  0,  0, 1'b0, 1'b0},
        '{10, 10, 10,  9, 8'hbf, 8'h7f, 8'h00, 1'b0,  0,  0, 1'b0, 1'b0},
        '{ 5,  5,  6,  6, 8'h99, 8'h66, 8'h33, 1'b0,  0,  0, 1'b0, 1'b0},
        '{ 3,  7, 12,  9, 8'h11, 8'h22, 8'h44, 1'b0,  0,  0, 1'b0, 1'b0},
        '{40,  2, 37, 30, 8'h88, 8'hcc, 8'hee, 1'b0,  0,  0, 1'b0, 1'b0},
        '{ 0, 63, 63,  0, 8'h5a, 8'ha5, 8'h5a, 1'b0,  0,  0, 1'b0, 1'b0},
        '{31, 32, 32, 31, 8'h7f, 8'h80, 8'h7f, 1'b0,  0,  0, 1'b0, 1'b0},
        '{63, 31,  0, 32, 8'h3f, 8'hc0, 8'h1e, 1'b0,  0,  0, 1'b0, 1'b0},
        '{ 1,  2,  3,  4, 8'h80, 8'h01, 8'hfe, 1'b0,  0,  0, 1'b0, 1'b0}
    };

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    pixel_t     pixel_q [$];
    int         err_cnt = 0;
    int         s_idle_pct = 0;
    int         r_idle_pct = 0;
    bit         hold_req = 1'b0;
    logic [6:0] img_w = IMAGE_SIZE_RST;
    logic [6:0] img_h = IMAGE_SIZE_RST;

    bresenham_line_rasterizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Expected pixels of one line, walked with the current image size.
    task automatic plot_line(input line_cmd_t c);
        int x, y, dx, dy, sx, sy, major, minor, err;
        bit xmajor;
        pixel_t p;
        x      = c.x0;
        y      = c.y0;
        dx     = (c.x1 > c.x0) ? c.x1 - c.x0 : c.x0 - c.x1;
        dy     = (c.y1 > c.y0) ? c.y1 - c.y0 : c.y0 - c.y1;
        sx     = (c.x0 < c.x1) ? 1 : -1;
        sy     = (c.y0 < c.y1) ? 1 : -1;
        xmajor = dx > dy;
        major  = xmajor ? dx : dy;
        minor  = xmajor ? dy : dx;
        err    = major / 2;
        p.r    = c.r;
        p.g    = c.g;
        p.b    = c.b;
        for (int i = -1; i < major; i++)
        begin
            if (i >= 0)
            begin
                if (xmajor)
                    x += sx;
                else
                    y += sy;
                err += minor;
                if (err > major)
                begin
                    err -= major;
                    if (xmajor)
                        y += sy;
                    else
                        x += sx;
                end
            end
            p.x      = x[5:0];
            p.y      = y[5:0];
            p.in_img = (x < int'(img_w)) && (y < int'(img_h));
            p.plast  = (i == major - 1);
            pixel_q.push_back(p);
        end
    endtask

    function automatic line_cmd_t rand_line();
        line_cmd_t c;
        int kind;
        kind = $urandom_range(99);
        c.x0 = 6'($urandom_range(63));
        c.y0 = 6'($urandom_range(63));
        c.r  = 8'($urandom_range(255));
        c.g  = 8'($urandom_range(255));
        c.b  = 8'($urandom_range(255));
        if (kind < 70)
        begin
            // short lines keep the run fast
            c.x1 = 6'($urandom_range(c.x0 < 57 ? c.x0 + 6 : 63, c.x0 > 6 ? c.x0 - 6 : 0));
            c.y1 = 6'($urandom_range(c.y0 < 57 ? c.y0 + 6 : 63, c.y0 > 6 ? c.y0 - 6 : 0));
        end
        else if (kind < 90)
        begin
            c.x1 = 6'($urandom_range(63));
            c.y1 = 6'($urandom_range(63));
        end
        else
        begin
            c.x0 = $urandom_range(1) ? 6'd63 : 6'd0;
            c.y0 = $urandom_range(1) ? 6'd63 : 6'd0;
            c.x1 = $urandom_range(1) ? 6'd63 : 6'd0;
            c.y1 = $urandom_range(1) ? 6'd63 : 6'd0;
        end
        return c;
    endfunction

    // Leaves s_tvalid high after the request is taken.
    task automatic send_line(input line_cmd_t c, input bit typed, input pixel_t want);
        while ($urandom_range(99) < s_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.b, c.g, c.r, c.y1, c.x1, c.y0, c.x0};
        do
            @(posedge clk);
        while (!s_tready);
        if (typed)
            pixel_q.push_back(want);
        else
            plot_line(c);
    endtask

    // Leaves cfg_valid high after the write is taken.
    task automatic write_reg(input cfg_idx_t idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_IMAGE_WIDTH)
            img_w = val;
        else
            img_h = val;
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            err_cnt++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t unexpected pixel: expected none actual %h", $time, m_tdata);
            end
            else
            begin
                want = pixel_q.pop_front();
                check_field("pixel_x", want.x, m_tdata[5:0]);
                check_field("pixel_y", want.y, m_tdata[11:6]);
                check_field("in_img", want.in_img, m_tuser);
                check_field("red", want.r, m_tdata[19:12]);
                check_field("green", want.g, m_tdata[27:20]);
                check_field("blue", want.b, m_tdata[35:28]);
                check_field("last", want.plast, m_tlast);
            end
        end
    end

    // Pixel sink with random stalls and one long hold-off on request.
    initial
    begin : pixel_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= r_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        pixel_t     want;
        logic [6:0] new_w, new_h;
        s_idle_pct = 33;
        r_idle_pct = 82;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            want = '{DIRECTED[i].ex, DIRECTED[i].ey, DIRECTED[i].ein, DIRECTED[i].r,
                     DIRECTED[i].g, DIRECTED[i].b, DIRECTED[i].elast};
            send_line('{DIRECTED[i].x0, DIRECTED[i].y0, DIRECTED[i].x1, DIRECTED[i].y1,
                        DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b},
                      DIRECTED[i].typed, want);
        end
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: begin new_w = 7'd0;   new_h = 7'd127; end
                1: begin new_w = 7'd127; new_h = 7'd0;   end
                2: begin new_w = 7'd1;   new_h = 7'd1;   end
                3: begin new_w = 7'd64;  new_h = 7'd1;   end
                4: begin new_w = 7'($urandom_range(64, 1)); new_h = 7'($urandom_range(64, 1)); end
                default: begin new_w = 7'($urandom_range(127)); new_h = 7'($urandom_range(127)); end
            endcase
            write_reg(REG_IMAGE_WIDTH, new_w);
            write_reg(REG_IMAGE_HEIGHT, new_h);
            cfg_valid <= 1'b0;
            // sender/sink idle mix: mostly sink stalls, then mostly sender gaps, then none
            s_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 82 : 0;
            r_idle_pct = (ph < 2) ? 82 : (ph < 4) ? 33 : 0;
            if (ph == PHASES - 1)
                hold_req = 1'b1;
            for (int n = 0; n < LINES_PER_PH; n++)
                send_line(rand_line(), 1'b0, want);
            s_tvalid <= 1'b0;
        end

        wait_drained();
        if (err_cnt == 0 && pixel_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bres_pkg.sv
hw/rtl/bres_step.sv
hw/rtl/bresenham_line_rasterizer.sv
hw/rtl/bres_chk.sv
verif/tb_bresenham_line_rasterizer.sv
